>>> src/lkvc_pkg.sv
// shared constants, types and helper function of the lru key/value cache
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int RANK_W     = IDX_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // operation codes carried in the kind field
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

    // index of the lowest set bit, zero when none is set
    function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> src/lkvc_if.sv
// handshake channel interfaces: request, response and configuration write

interface lkvc_req_if import lkvc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
    logic                         evicted;
    logic signed [KEY_BITS-1:0]   evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lkvc_cfg_if import lkvc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> src/lkvc_ctrl.sv
// controller state machine: accept, lookup, then commit into the output register
module lkvc_ctrl import lkvc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_status i_status,
    output logic    o_req_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a word is only taken when idle, and lookup always follows it
    a_capture_then_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.lookup)
        else $error("lookup did not follow capture");

    // lookup is followed by the update state
    a_lookup_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lookup |=> (r_state == ST_UPDATE))
        else $error("update state did not follow lookup");

    // commit never lands while the output register is blocked
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_status.out_free)
        else $error("commit while output register busy");
`endif

endmodule

>>> src/lkvc_datapath.sv
// datapath: entry store, recency ranks, lookup registers and output register
module lkvc_datapath import lkvc_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    input  logic                         i_kind,
    input  logic signed [KEY_BITS-1:0]   i_key,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_cfg_valid,
    input  logic [CAP_W-1:0]             i_cfg_data,
    lkvc_rsp_if.source                   o_rsp
);

    // entry store
    logic [KEY_BITS-1:0]   r_keys   [ENTRIES];
    logic [VALUE_BITS-1:0] r_values [ENTRIES];
    logic [RANK_W-1:0]     r_rank   [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [CNT_W-1:0]      r_occ;
    logic [CAP_W-1:0]      r_capacity;

    // captured request
    logic                  r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // lookup results
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_slot;
    logic                  r_evict;
    logic                  r_cap_zero;
    logic [IDX_W-1:0]      r_lru_slot;
    logic [IDX_W-1:0]      r_free_slot;

    // output register
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_evicted;
    logic [KEY_BITS-1:0]   r_out_evk;

    logic [ENTRIES-1:0]    w_hit_vec;
    logic [ENTRIES-1:0]    w_lru_vec;
    logic [ENTRIES-1:0]    w_free_vec;
    logic [CNT_W-1:0]      w_cap;
    logic                  w_need_evict;
    logic [RANK_W-1:0]     w_hit_rank;
    logic                  w_out_free;

    // effective capacity, clamped to the number of entries
    always_comb begin
        if (int'(r_capacity) > ENTRIES) begin
            w_cap = CNT_W'(ENTRIES);
        end else begin
            w_cap = CNT_W'(r_capacity);
        end
    end

    // parallel key compare and least recent / free slot search
    always_comb begin
        w_need_evict = (r_occ >= w_cap);
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_vec[i] = r_valid[i] && (r_keys[i] == r_key);
            w_lru_vec[i] = r_valid[i] && ((CNT_W'(r_rank[i]) + CNT_W'(1)) == r_occ);
        end
        w_free_vec = ~r_valid | (w_need_evict ? w_lru_vec : '0);
    end

    assign w_hit_rank = r_rank[r_hit_slot];
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign o_status.out_free = w_out_free;

    // request capture and lookup registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_key   <= KEY_BITS'(i_key);
            r_value <= VALUE_BITS'(i_value);
        end
        if (i_cmd.lookup) begin
            r_hit       <= |w_hit_vec;
            r_hit_slot  <= first_set(w_hit_vec);
            r_cap_zero  <= (w_cap == '0);
            r_evict     <= w_need_evict && (w_cap != '0);
            r_lru_slot  <= first_set(w_lru_vec);
            r_free_slot <= first_set(w_free_vec);
        end
    end

    // store payload: keys, values and ranks
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_cap_zero) begin
            if (r_hit) begin
                if (r_kind == KIND_PUT) begin
                    r_values[r_hit_slot] <= r_value;
                end
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
                r_rank[r_hit_slot] <= '0;
            end else if (r_kind == KIND_PUT) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && !(r_evict && (IDX_W'(i) == r_lru_slot))) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
                r_keys[r_free_slot]   <= r_key;
                r_values[r_free_slot] <= r_value;
                r_rank[r_free_slot]   <= '0;
            end
        end else if (i_cmd.commit && r_hit) begin
            // capacity zero holds no entry, so a hit cannot occur here
            r_rank[r_hit_slot] <= '0;
        end
    end

    // valid bits, occupancy and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_occ      <= '0;
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
            r_valid    <= '0;
            r_occ      <= '0;
        end else if (i_cmd.commit && !r_hit && (r_kind == KIND_PUT) && !r_cap_zero) begin
            if (r_evict) begin
                r_valid[r_lru_slot] <= 1'b0;
                r_occ               <= r_occ;
            end else begin
                r_occ <= r_occ + CNT_W'(1);
            end
            r_valid[r_free_slot] <= 1'b1;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit     <= r_hit;
            r_out_value   <= '0;
            r_out_evicted <= 1'b0;
            r_out_evk     <= '0;
            if (r_hit) begin
                if (r_kind == KIND_GET) begin
                    r_out_value <= r_values[r_hit_slot];
                end
            end else if (r_kind == KIND_GET) begin
                r_out_value <= '1;
            end else if (r_cap_zero) begin
                r_out_evicted <= 1'b1;
                r_out_evk     <= r_key;
            end else if (r_evict) begin
                r_out_evicted <= 1'b1;
                r_out_evk     <= r_keys[r_lru_slot];
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_value;
    assign o_rsp.evicted     = r_out_evicted;
    assign o_rsp.evicted_key = r_out_evk;

`ifndef NO_ASSERTIONS
    // occupancy tracks the number of valid entries
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy does not match valid entries");

    // occupancy never exceeds the clamped capacity
    a_occ_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= w_cap)
        else $error("occupancy above capacity");

    // an eviction is never reported together with a hit
    a_evict_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_evicted |-> !r_out_hit)
        else $error("eviction reported on a hit");

    // a commit into a blocked output register would drop a word
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> w_out_free)
        else $error("output word overwritten");
`endif

endmodule

>>> src/lru_key_value_cache_core.sv
// top level of the lru key/value cache: controller and datapath
//
// Usage:
//   i_req carries one word per operation: kind (get or put), key, value.
//   o_rsp returns one word per operation: hit, read_value, evicted and
//   evicted_key. i_cfg writes the capacity register; any write empties the
//   store. Write capacity only while no operation is in flight.
// Timing:
//   a word accepted in the idle state is looked up in the lookup state (all
//   16 keys compared at once, least recent and first free slot found), and
//   committed into the store and the output register in the update state,
//   which waits while the output register is blocked. A new word is taken
//   only after that commit, so operations never overlap; the registered
//   lookup stage lies between the key compare and the store update.
// Stalls:
//   a result waiting in the output register does not block acceptance or
//   lookup of the next word; only its commit waits for o_rsp.ready.
// Reset:
//   synchronous, active low; the store empties and capacity returns to 16.
//   Out of reset, configuration writes are always taken (i_cfg.ready high).
module lru_key_value_cache_core import lkvc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lkvc_req_if.sink   i_req,
    lkvc_rsp_if.source o_rsp,
    lkvc_cfg_if.sink   i_cfg
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_req_ready;

    // sequencing
    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    // store and result path
    lkvc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_kind      (i_req.kind),
        .i_key       (i_req.key),
        .i_value     (i_req.value),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_rsp       (o_rsp)
    );

    // nothing is taken while reset is held
    assign i_req.ready = w_req_ready && i_rst_n;
    assign i_cfg.ready = i_rst_n;

endmodule
